// File: hdl/coherent_window_averager_assert.svh
// Assertion macros for the coherent window averager.
// Included by the top level only; no other dependencies.
`ifndef COHERENT_WINDOW_AVERAGER_ASSERT_SVH
`define COHERENT_WINDOW_AVERAGER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CWA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CWA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CWA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define CWA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: hdl/cwa_pkg.sv
// Shared constants, types and register codes of the coherent window averager.
// No dependencies.
package cwa_pkg;

   localparam int MAX_WINDOW  = 1024;
   localparam int MAX_AVERAGE = 256;

   localparam int POS_W     = $clog2(MAX_WINDOW);
   localparam int WIN_CNT_W = $clog2(MAX_AVERAGE);
   localparam int SMP_W     = 16;
   localparam int ACC_W     = 24;
   localparam int SUM_W     = ACC_W + 1;
   localparam int MEM_W     = 2 * ACC_W;

   localparam int AVG_CFG_W  = 9;
   localparam int LEN_CFG_W  = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_ADDR_W = 1;
   localparam int AVG_RESET  = 1;
   localparam int LEN_RESET  = 1024;

   localparam int MAG_W     = ACC_W;
   localparam int DIV_STEP  = 4;
   localparam int DIV_ITER  = MAG_W / DIV_STEP;
   localparam int DIV_CNT_W = $clog2(DIV_ITER);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_AVERAGE_COUNT = 1'b0,
      CSR_WINDOW_LENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] sum_re;
      logic signed [SUM_W-1:0] sum_im;
      logic [AVG_CFG_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [SMP_W-1:0] q_re;
      logic signed [SMP_W-1:0] q_im;
   } div_rsp_type;

endpackage

// File: hdl/coherent_window_averager.sv
// Coherent window averager: per-position I/Q accumulation in a window RAM.
// Depends on cwa_pkg, cwa_ram, cwa_div and coherent_window_averager_assert.svh.
//
// Usage:
//   req_ channel carries one complex Q1.15 sample per item. Each sample is added
//   into the accumulator entry of its position in the window. During the last of
//   average_count windows every sample gives one item on rsp_: the accumulated
//   sum plus that sample, divided by average_count, truncated toward zero;
//   rsp_tlast marks the last sample of the window. The csr_ port sets
//   average_count (index 0) and window_length (index 1); write only when idle.
//   Flow: the accumulator RAM is read at accept and written back in the next
//   cycle, in ST_CALC; an item that gives no result then returns to ST_IDLE. An
//   item of the last window also runs the iterative divider (4 quotient bits
//   per step) in ST_DIV and is delivered to the output register from ST_FIN;
//   no new sample is taken until that item has entered the output register.
//   Reset: registers go to average_count 1 and window_length 1024, and a
//   clearing pass writes zero to all 1024 RAM entries; req_tready stays low
//   until that pass has finished.
//   Stall: the output register holds its item while rsp_tready is low; the
//   next sample is still taken and accumulated, and a further result waits
//   inside the block until the output register frees.
module coherent_window_averager (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [2*cwa_pkg::SMP_W-1:0]     req_tdata,  // sample_re, sample_im
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [2*cwa_pkg::SMP_W-1:0]     rsp_tdata,  // avg_re, avg_im
   output logic                            rsp_tlast,  // window_end
   input  logic                            csr_we,
   input  logic [cwa_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [cwa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

`include "coherent_window_averager_assert.svh"

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_CALC  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   localparam int SMP_W = cwa_pkg::SMP_W;
   localparam int ACC_W = cwa_pkg::ACC_W;
   localparam int SUM_W = cwa_pkg::SUM_W;
   localparam int POS_W = cwa_pkg::POS_W;
   localparam int AW    = cwa_pkg::AVG_CFG_W;
   localparam int LW    = cwa_pkg::LEN_CFG_W;

   state_type                      state_ff, state_in;
   logic [AW-1:0]                  avg_cfg_ff, avg_cfg_in;
   logic [LW-1:0]                  len_cfg_ff, len_cfg_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [cwa_pkg::WIN_CNT_W-1:0]  wd_ff, wd_in;
   logic [POS_W-1:0]               clr_addr_ff, clr_addr_in;
   logic [POS_W-1:0]               pos_lat_ff, pos_lat_in;
   logic signed [SMP_W-1:0]        smp_re_ff, smp_re_in, smp_im_ff, smp_im_in;
   logic                           last_smp_ff, last_smp_in, last_win_ff, last_win_in;
   logic [AW-1:0]                  m_lat_ff, m_lat_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [2*SMP_W-1:0]             rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           accept;
   logic [AW-1:0]                  m_cl;
   logic [LW-1:0]                  len_cl;
   logic                           last_sample, last_window;
   logic                           mem_we;
   logic [POS_W-1:0]               mem_waddr;
   logic [cwa_pkg::MEM_W-1:0]      mem_wdata, mem_rdata;
   logic signed [SUM_W-1:0]        sum_re, sum_im;
   cwa_pkg::div_req_type           div_req;
   cwa_pkg::div_rsp_type           div_rsp;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] s);
      logic signed [ACC_W-1:0] r;
      if (s[SUM_W-1] != s[SUM_W-2]) begin
         r = s[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = s[ACC_W-1:0];
      end
      return r;
   endfunction

   cwa_ram #(
      .DEPTH(cwa_pkg::MAX_WINDOW),
      .WIDTH(cwa_pkg::MEM_W)
   ) u_acc_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (accept),
      .rd_addr(pos_ff),
      .rd_data(mem_rdata)
   );

   cwa_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (avg_cfg_ff == '0) begin
         m_cl = AW'(1);
      end else if (avg_cfg_ff > AW'(cwa_pkg::MAX_AVERAGE)) begin
         m_cl = AW'(cwa_pkg::MAX_AVERAGE);
      end else begin
         m_cl = avg_cfg_ff;
      end
      if (len_cfg_ff == '0) begin
         len_cl = LW'(1);
      end else if (len_cfg_ff > LW'(cwa_pkg::MAX_WINDOW)) begin
         len_cl = LW'(cwa_pkg::MAX_WINDOW);
      end else begin
         len_cl = len_cfg_ff;
      end
      last_sample = (LW'(pos_ff) + LW'(1)) >= len_cl;
      last_window = (AW'(wd_ff) + AW'(1)) >= m_cl;
   end

   assign sum_re = SUM_W'(signed'(mem_rdata[ACC_W-1:0])) + SUM_W'(smp_re_ff);
   assign sum_im = SUM_W'(signed'(mem_rdata[2*ACC_W-1:ACC_W])) + SUM_W'(smp_im_ff);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pos_lat_ff;
      mem_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
      end else if (state_ff == ST_CALC) begin
         mem_we = 1'b1;
         if (!last_win_ff) begin
            mem_wdata = {sat_acc(sum_im), sat_acc(sum_re)};
         end
      end
   end

   assign div_req.start   = (state_ff == ST_CALC) && last_win_ff;
   assign div_req.sum_re  = sum_re;
   assign div_req.sum_im  = sum_im;
   assign div_req.divisor = m_lat_ff;

   always_comb begin
      state_in     = state_ff;
      avg_cfg_in   = avg_cfg_ff;
      len_cfg_in   = len_cfg_ff;
      pos_in       = pos_ff;
      wd_in        = wd_ff;
      clr_addr_in  = clr_addr_ff;
      pos_lat_in   = pos_lat_ff;
      smp_re_in    = smp_re_ff;
      smp_im_in    = smp_im_ff;
      last_smp_in  = last_smp_ff;
      last_win_in  = last_win_ff;
      m_lat_in     = m_lat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_we) begin
         case (cwa_pkg::csr_index_type'(csr_addr))
            cwa_pkg::CSR_AVERAGE_COUNT: begin
               avg_cfg_in = csr_wdata[AW-1:0];
            end
            cwa_pkg::CSR_WINDOW_LENGTH: begin
               len_cfg_in = csr_wdata[LW-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == POS_W'(cwa_pkg::MAX_WINDOW - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               pos_lat_in  = pos_ff;
               smp_re_in   = req_tdata[SMP_W-1:0];
               smp_im_in   = req_tdata[2*SMP_W-1:SMP_W];
               last_smp_in = last_sample;
               last_win_in = last_window;
               m_lat_in    = m_cl;
               if (last_sample) begin
                  pos_in = '0;
                  wd_in  = last_window ? '0 : wd_ff + 1'b1;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = last_win_ff ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {div_rsp.q_im, div_rsp.q_re};
               rsp_last_in  = last_smp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         avg_cfg_ff   <= AW'(cwa_pkg::AVG_RESET);
         len_cfg_ff   <= LW'(cwa_pkg::LEN_RESET);
         pos_ff       <= '0;
         wd_ff        <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avg_cfg_ff   <= avg_cfg_in;
         len_cfg_ff   <= len_cfg_in;
         pos_ff       <= pos_in;
         wd_ff        <= wd_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_lat_ff  <= pos_lat_in;
      smp_re_ff   <= smp_re_in;
      smp_im_ff   <= smp_im_in;
      last_smp_ff <= last_smp_in;
      last_win_ff <= last_win_in;
      m_lat_ff    <= m_lat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `CWA_ASSERT_NEXT(a_accept_to_calc, clock, reset, accept, state_ff == ST_CALC, "accept did not start the read-modify-write")
   `CWA_ASSERT_IMPLY(a_done_in_div, clock, reset, div_rsp.done, state_ff == ST_DIV, "divider finished outside the divide state")
   `CWA_ASSERT_NEXT(a_fin_holds, clock, reset, (state_ff == ST_FIN) && rsp_valid_ff && !rsp_tready, (state_ff == ST_FIN) && rsp_valid_ff, "pending result dropped while output stalled")

endmodule

// File: hdl/cwa_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependencies.
module cwa_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cwa_div.sv
// Iterative signed divider for the I/Q sums, DIV_STEP quotient bits per cycle.
// Truncates toward zero and saturates to the sample range. Uses cwa_pkg.
module cwa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  cwa_pkg::div_req_type req,
   output cwa_pkg::div_rsp_type rsp
);

   localparam int REM_W = cwa_pkg::AVG_CFG_W;

   logic [cwa_pkg::MAG_W-1:0]     mag_re_ff, mag_re_in, mag_im_ff, mag_im_in;
   logic [REM_W-1:0]              rem_re_ff, rem_re_in, rem_im_ff, rem_im_in;
   logic                          neg_re_ff, neg_re_in, neg_im_ff, neg_im_in;
   logic [REM_W-1:0]              dvs_ff, dvs_in;
   logic [cwa_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in, done_ff, done_in;
   logic [cwa_pkg::MAG_W-1:0]     step_mag_re, step_mag_im;
   logic [REM_W-1:0]              step_rem_re, step_rem_im;

   function automatic logic [cwa_pkg::MAG_W-1:0] abs_sum(
      input logic signed [cwa_pkg::SUM_W-1:0] s);
      logic [cwa_pkg::SUM_W-1:0] a;
      a = s[cwa_pkg::SUM_W-1] ? cwa_pkg::SUM_W'(-s) : cwa_pkg::SUM_W'(s);
      return a[cwa_pkg::MAG_W-1:0];
   endfunction

   function automatic logic [cwa_pkg::MAG_W+REM_W-1:0] div_steps(
      input logic [cwa_pkg::MAG_W-1:0] mag, input logic [REM_W-1:0] rem,
      input logic [REM_W-1:0] dvs);
      logic [cwa_pkg::MAG_W-1:0] m;
      logic [REM_W-1:0]          r;
      logic [REM_W:0]            sh;
      m = mag;
      r = rem;
      for (int k = 0; k < cwa_pkg::DIV_STEP; k++) begin
         sh = {r, m[cwa_pkg::MAG_W-1]};
         m  = {m[cwa_pkg::MAG_W-2:0], 1'b0};
         if (sh >= {1'b0, dvs}) begin
            r    = REM_W'(sh - {1'b0, dvs});
            m[0] = 1'b1;
         end else begin
            r = sh[REM_W-1:0];
         end
      end
      return {m, r};
   endfunction

   function automatic logic signed [cwa_pkg::SMP_W-1:0] sat_q(
      input logic [cwa_pkg::MAG_W-1:0] q, input logic neg);
      logic signed [cwa_pkg::SMP_W-1:0] res;
      if (neg) begin
         if (q > cwa_pkg::MAG_W'(2 ** (cwa_pkg::SMP_W - 1))) begin
            res = {1'b1, {(cwa_pkg::SMP_W-1){1'b0}}};
         end else begin
            res = cwa_pkg::SMP_W'(-q);
         end
      end else begin
         if (q > cwa_pkg::MAG_W'(2 ** (cwa_pkg::SMP_W - 1) - 1)) begin
            res = {1'b0, {(cwa_pkg::SMP_W-1){1'b1}}};
         end else begin
            res = q[cwa_pkg::SMP_W-1:0];
         end
      end
      return res;
   endfunction

   always_comb begin
      {step_mag_re, step_rem_re} = div_steps(mag_re_ff, rem_re_ff, dvs_ff);
      {step_mag_im, step_rem_im} = div_steps(mag_im_ff, rem_im_ff, dvs_ff);

      mag_re_in = mag_re_ff;
      mag_im_in = mag_im_ff;
      rem_re_in = rem_re_ff;
      rem_im_in = rem_im_ff;
      neg_re_in = neg_re_ff;
      neg_im_in = neg_im_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;

      if (req.start) begin
         mag_re_in = abs_sum(req.sum_re);
         mag_im_in = abs_sum(req.sum_im);
         neg_re_in = req.sum_re[cwa_pkg::SUM_W-1];
         neg_im_in = req.sum_im[cwa_pkg::SUM_W-1];
         rem_re_in = '0;
         rem_im_in = '0;
         dvs_in    = req.divisor;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         mag_re_in = step_mag_re;
         mag_im_in = step_mag_im;
         rem_re_in = step_rem_re;
         rem_im_in = step_rem_im;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == cwa_pkg::DIV_CNT_W'(cwa_pkg::DIV_ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_re_ff <= mag_re_in;
      mag_im_ff <= mag_im_in;
      rem_re_ff <= rem_re_in;
      rem_im_ff <= rem_im_in;
      neg_re_ff <= neg_re_in;
      neg_im_ff <= neg_im_in;
      dvs_ff    <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.q_re = sat_q(mag_re_ff, neg_re_ff);
   assign rsp.q_im = sat_q(mag_im_ff, neg_im_ff);

endmodule

// File: verif/tb_coherent_window_averager.sv
`timescale 1ns / 100ps
// Testbench for coherent_window_averager: directed and random I/Q sample streams,
// each average checked against a predictor of the window accumulation.
// Depends on cwa_pkg and the coherent_window_averager RTL.
module tb_coherent_window_averager;

   localparam int SMP_W       = cwa_pkg::SMP_W;
   localparam int ACC_W       = cwa_pkg::ACC_W;
   localparam int AVG_CFG_W   = cwa_pkg::AVG_CFG_W;
   localparam int LEN_CFG_W   = cwa_pkg::LEN_CFG_W;
   localparam int CSR_DATA_W  = cwa_pkg::CSR_DATA_W;
   localparam int CSR_ADDR_W  = cwa_pkg::CSR_ADDR_W;
   localparam int MAX_WINDOW  = cwa_pkg::MAX_WINDOW;
   localparam int MAX_AVERAGE = cwa_pkg::MAX_AVERAGE;

   localparam int LIMIT_CYCLES  = 250000;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 5000;
   localparam int ITEM_TARGET   = 1050;
   localparam int AVG_EXTREMES [4] = '{255, 256, 257, 511};
   localparam int LEN_EXTREMES [4] = '{1023, 1024, 1025, 2047};

   typedef struct {
      logic signed [SMP_W-1:0] avg_re;
      logic signed [SMP_W-1:0] avg_im;
      logic                    window_end;
   } average_item_type;

   class averager_scoreboard;
      int                      mismatches;
      logic [AVG_CFG_W-1:0]    average_count;
      logic [LEN_CFG_W-1:0]    window_length;
      logic signed [ACC_W-1:0] acc_re [MAX_WINDOW];
      logic signed [ACC_W-1:0] acc_im [MAX_WINDOW];
      int                      sample_position;
      int                      windows_done;
      average_item_type        awaited_averages [$];

      function new();
         average_count = cwa_pkg::AVG_RESET;
         window_length = cwa_pkg::LEN_RESET;
         foreach (acc_re[i]) begin
            acc_re[i] = '0;
            acc_im[i] = '0;
         end
         sample_position = 0;
         windows_done = 0;
         mismatches = 0;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         if (v > hi)
            return hi;
         if (v < lo)
            return lo;
         return v;
      endfunction

      task report(string what);
         if (mismatches < 30)
            $display("mismatch: %s", what);
         mismatches++;
      endtask

      function void set_register(cwa_pkg::csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            cwa_pkg::CSR_AVERAGE_COUNT: average_count = value[AVG_CFG_W-1:0];
            cwa_pkg::CSR_WINDOW_LENGTH: window_length = value[LEN_CFG_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_sample(logic signed [SMP_W-1:0] re, logic signed [SMP_W-1:0] im);
         int               m;
         int               len;
         int               pos;
         bit               last_sample;
         bit               last_window;
         longint           sum_re;
         longint           sum_im;
         average_item_type avg;
         m = average_count;
         if (m == 0)
            m = 1;
         if (m > MAX_AVERAGE)
            m = MAX_AVERAGE;
         len = window_length;
         if (len == 0)
            len = 1;
         if (len > MAX_WINDOW)
            len = MAX_WINDOW;
         pos = sample_position;
         if (pos >= MAX_WINDOW)
            pos = MAX_WINDOW - 1;
         last_sample = (pos + 1 >= len);
         last_window = (windows_done + 1 >= m);
         sum_re = longint'(acc_re[pos]) + longint'(re);
         sum_im = longint'(acc_im[pos]) + longint'(im);
         if (last_window) begin
            avg.avg_re = SMP_W'(clip(sum_re / m, -32768, 32767));
            avg.avg_im = SMP_W'(clip(sum_im / m, -32768, 32767));
            avg.window_end = last_sample;
            awaited_averages.push_back(avg);
            acc_re[pos] = '0;
            acc_im[pos] = '0;
         end else begin
            acc_re[pos] = ACC_W'(clip(sum_re, -8388608, 8388607));
            acc_im[pos] = ACC_W'(clip(sum_im, -8388608, 8388607));
         end
         if (last_sample) begin
            sample_position = 0;
            windows_done = last_window ? 0 : windows_done + 1;
         end else begin
            sample_position = pos + 1;
         end
      endfunction

      task compare_average(logic [2*SMP_W-1:0] data, logic window_end);
         average_item_type want;
         if (awaited_averages.size() == 0) begin
            report($sformatf("average %h end %b with none expected", data, window_end));
            return;
         end
         want = awaited_averages.pop_front();
         if (data[SMP_W-1:0] !== want.avg_re)
            report($sformatf("avg_re %h, expected %h", data[SMP_W-1:0], want.avg_re));
         if (data[2*SMP_W-1:SMP_W] !== want.avg_im)
            report($sformatf("avg_im %h, expected %h", data[2*SMP_W-1:SMP_W], want.avg_im));
         if (window_end !== want.window_end)
            report($sformatf("window_end %b, expected %b", window_end, want.window_end));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [2*SMP_W-1:0]    req_tdata = '0;   // sample_re, sample_im
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [2*SMP_W-1:0]    rsp_tdata;        // avg_re, avg_im
   logic                  rsp_tlast;        // window_end
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   averager_scoreboard board = new();
   int items_sent = 0;
   int cycle_count = 0;
   int ready_mode = 0;
   int ready_left = 0;

   coherent_window_averager dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb_coherent_window_averager failed");
         $finish;
      end
   end

   // receiver: changing stall modes, including stretches of no stall
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(3);
         ready_left = $urandom_range(16, 160);
      end
      ready_left--;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(1));
         2: rsp_tready <= (ready_left % 4 == 0);
         default: rsp_tready <= (ready_left % 11 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         board.compare_average(rsp_tdata, rsp_tlast);
   end

   function automatic logic [SMP_W-1:0] corner_value();
      case ($urandom_range(3))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'hffff;
      endcase
   endfunction

   task automatic send_sample(input logic signed [SMP_W-1:0] re,
                              input logic signed [SMP_W-1:0] im);
      req_tdata <= {im, re};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      board.take_sample(re, im);
      items_sent++;
   endtask

   task automatic write_register(input cwa_pkg::csr_index_type idx, input int value);
      while (board.awaited_averages.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      board.set_register(idx, CSR_DATA_W'(value));
      csr_we <= 1'b0;
   endtask

   // heavy: same-sign near-full-scale samples to drive accumulators into saturation
   task automatic stream_samples(input int count, input bit heavy);
      int                      burst;
      int                      gap;
      logic signed [SMP_W-1:0] re;
      logic signed [SMP_W-1:0] im;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            burst = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if (heavy) begin
            re = SMP_W'($urandom_range(28000, 32767));
            im = SMP_W'(-int'($urandom_range(28000, 32768)));
         end else if ($urandom_range(4) == 0) begin
            re = corner_value();
            im = corner_value();
         end else begin
            {im, re} = $urandom();
         end
         send_sample(re, im);
         burst--;
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int  m_value;
      int  l_value;
      bit  saturation_done;
      saturation_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: one group per window, 1024 positions
      send_sample(16'sh7fff, 16'sh8000);
      send_sample(16'sh8000, 16'sh7fff);
      send_sample(16'sh0000, 16'shffff);
      send_sample(16'shffff, 16'sh0000);
      req_tvalid <= 1'b0;

      // zero counts fall back to one; position already past the new length
      write_register(cwa_pkg::CSR_AVERAGE_COUNT, 0);
      write_register(cwa_pkg::CSR_WINDOW_LENGTH, 0);
      send_sample(16'sd12345, -16'sd12345);
      send_sample(16'sd1, -16'sd1);
      req_tvalid <= 1'b0;

      // three-window average, truncation toward zero on negative sums
      write_register(cwa_pkg::CSR_AVERAGE_COUNT, 3);
      write_register(cwa_pkg::CSR_WINDOW_LENGTH, 2);
      send_sample(-16'sd1, 16'sd1);
      send_sample(16'sh8000, 16'sh7fff);
      send_sample(-16'sd1, 16'sd1);
      send_sample(16'sh7fff, 16'sh8000);
      send_sample(-16'sd2, 16'sd2);
      send_sample(16'sh8000, 16'sh7fff);
      req_tvalid <= 1'b0;

      // register values above the supported maxima
      write_register(cwa_pkg::CSR_AVERAGE_COUNT, 2);
      write_register(cwa_pkg::CSR_WINDOW_LENGTH, 2047);
      send_sample(16'sh7fff, 16'sh7fff);
      send_sample(16'sh7fff, 16'sh7fff);
      req_tvalid <= 1'b0;
      write_register(cwa_pkg::CSR_AVERAGE_COUNT, 511);
      send_sample(16'sh8000, 16'sh8000);
      send_sample(16'sh8000, 16'sh8000);
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (items_sent < ITEM_TARGET) begin
         if (!saturation_done && items_sent >= 300) begin
            // resync to position 0, then pile one entry past the 24-bit limits
            write_register(cwa_pkg::CSR_AVERAGE_COUNT, 1);
            write_register(cwa_pkg::CSR_WINDOW_LENGTH, 1);
            stream_samples(2, 1'b0);
            write_register(cwa_pkg::CSR_AVERAGE_COUNT, 256);
            stream_samples(254, 1'b1);
            write_register(cwa_pkg::CSR_WINDOW_LENGTH, 2);
            stream_samples(1, 1'b1);
            // end the group from position 1 so position 0 keeps its sum
            write_register(cwa_pkg::CSR_AVERAGE_COUNT, 1);
            stream_samples(1, 1'b1);
            write_register(cwa_pkg::CSR_AVERAGE_COUNT, 256);
            write_register(cwa_pkg::CSR_WINDOW_LENGTH, 1);
            stream_samples(254, 1'b1);
            // divide by one: quotient clamps to the 16-bit range
            write_register(cwa_pkg::CSR_AVERAGE_COUNT, 1);
            stream_samples(1, 1'b1);
            saturation_done = 1'b1;
         end else begin
            if ($urandom_range(3) != 0) begin
               case ($urandom_range(9))
                  0, 1, 2, 3, 4, 5: m_value = $urandom_range(0, 4);
                  6, 7: m_value = $urandom_range(5, 16);
                  8: m_value = AVG_EXTREMES[$urandom_range(3)];
                  default: m_value = $urandom_range(0, 2047);
               endcase
               write_register(cwa_pkg::CSR_AVERAGE_COUNT, m_value);
            end
            if ($urandom_range(3) != 0) begin
               case ($urandom_range(7))
                  0, 1, 2, 3: l_value = $urandom_range(0, 8);
                  4, 5: l_value = $urandom_range(9, 64);
                  6: l_value = LEN_EXTREMES[$urandom_range(3)];
                  default: l_value = $urandom_range(0, 2047);
               endcase
               write_register(cwa_pkg::CSR_WINDOW_LENGTH, l_value);
            end
            stream_samples($urandom_range(1, 40), 1'b0);
         end
      end

      for (int w = 0; w < DRAIN_CYCLES && board.awaited_averages.size() != 0; w++)
         @(posedge clock);
      repeat (32) @(posedge clock);
      if (board.awaited_averages.size() != 0)
         board.report($sformatf("%0d averages never arrived", board.awaited_averages.size()));
      if (board.mismatches == 0)
         $display("tb_coherent_window_averager passed");
      else
         $display("tb_coherent_window_averager failed");
      $finish;
   end

endmodule
